FILE: rtl/stp_pkg.sv
// Shared types and constants for the space-to-tab packer.
// Used by every module in rtl/; depends on nothing.
package stp_pkg;

   localparam int unsigned LINE_LENGTH_DEF = 82;
   localparam int unsigned TAB_WIDTH_DEF   = 4;
   localparam int unsigned LAST_STOP_DEF   = 79;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned RPT_W       = 7;
   // column compares run at this width so column + 1 and the stop never wrap
   localparam int unsigned CMP_W       = 8;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;

   // one queued operation: a tab run, a space run, then one byte
   typedef struct packed {
      logic [RPT_W-1:0]  tabs;
      logic [RPT_W-1:0]  spaces;
      logic [BYTE_W-1:0] ch;
      logic              last;
   } op_type;

endpackage

FILE: rtl/stp_front.sv
// Front end: accepts input beats, tracks column, quote and pending runs,
// and pushes one operation per emitting byte. Depends on stp_pkg.
module stp_front #(
   parameter int unsigned LINE_LENGTH = stp_pkg::LINE_LENGTH_DEF,
   parameter int unsigned TAB_WIDTH   = stp_pkg::TAB_WIDTH_DEF,
   parameter int unsigned LAST_STOP   = stp_pkg::LAST_STOP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [stp_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_end_of_line,
   input  logic                        q_full,
   output logic                        q_push,
   output stp_pkg::op_type             q_op
);

   localparam int unsigned COL_W = $clog2(LINE_LENGTH);
   localparam int unsigned MOD_W = $clog2(TAB_WIDTH);

   localparam logic [1:0] PH_NONE  = 2'd0;
   localparam logic [1:0] PH_APOS  = 2'd1;
   localparam logic [1:0] PH_SPACE = 2'd2;

   logic [COL_W-1:0]          column_ff, column_in;
   logic [MOD_W-1:0]          col_mod_ff, col_mod_in;
   logic                      in_quote_ff, in_quote_in;
   logic [stp_pkg::RPT_W-1:0] tabs_ff, tabs_in;
   logic [stp_pkg::RPT_W-1:0] spaces_ff, spaces_in;
   logic [1:0]                phase_ff, phase_in;

   logic                      accept;
   logic                      is_eol;
   logic                      ignore;
   logic [stp_pkg::CMP_W-1:0] col_next;
   logic                      stop_hit;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_eol    = req_end_of_line || (req_in_byte == stp_pkg::CH_NUL);
   assign ignore    = stp_pkg::CMP_W'(column_ff) >= stp_pkg::CMP_W'(LINE_LENGTH - 1);
   assign col_next  = stp_pkg::CMP_W'(column_ff) + stp_pkg::CMP_W'(1);

   // a run never crosses a stop without converting, so the run reaches its
   // stop exactly when the next column is a stop
   assign stop_hit = (col_next <= stp_pkg::CMP_W'(LAST_STOP)) &&
                     ((col_mod_ff == MOD_W'(TAB_WIDTH - 1)) ||
                      (col_next == stp_pkg::CMP_W'(LAST_STOP)));

   always_comb begin
      column_in   = column_ff;
      col_mod_in  = col_mod_ff;
      in_quote_in = in_quote_ff;
      tabs_in     = tabs_ff;
      spaces_in   = spaces_ff;
      phase_in    = phase_ff;
      q_push      = 1'b0;
      q_op.tabs   = tabs_ff;
      q_op.spaces = spaces_ff;
      q_op.ch     = req_in_byte;
      q_op.last   = 1'b0;

      if (accept) begin
         if (is_eol) begin
            q_push      = 1'b1;
            q_op.tabs   = '0;
            q_op.spaces = '0;
            q_op.ch     = stp_pkg::CH_CR;
            q_op.last   = 1'b1;
            column_in   = '0;
            col_mod_in  = '0;
            in_quote_in = 1'b0;
            tabs_in     = '0;
            spaces_in   = '0;
            phase_in    = PH_NONE;
         end else if (!ignore) begin
            column_in  = column_ff + COL_W'(1);
            col_mod_in = (col_mod_ff == MOD_W'(TAB_WIDTH - 1)) ? '0
                                                               : col_mod_ff + MOD_W'(1);
            if (req_in_byte == stp_pkg::CH_SPACE) begin
               phase_in = (phase_ff == PH_APOS) ? PH_SPACE : PH_NONE;
               if (!in_quote_ff && stop_hit) begin
                  tabs_in   = tabs_ff + stp_pkg::RPT_W'(1);
                  spaces_in = '0;
               end else begin
                  spaces_in = spaces_ff + stp_pkg::RPT_W'(1);
               end
            end else begin
               q_push    = 1'b1;
               tabs_in   = '0;
               spaces_in = '0;
               if (req_in_byte == stp_pkg::CH_APOS && phase_ff == PH_SPACE) begin
                  // quote-space-quote: one literal space, pending tab discarded
                  q_op.tabs   = '0;
                  q_op.spaces = stp_pkg::RPT_W'(1);
                  phase_in    = PH_NONE;
               end else begin
                  if (req_in_byte == stp_pkg::CH_QUOTE) begin
                     in_quote_in = !in_quote_ff;
                  end
                  phase_in = (req_in_byte == stp_pkg::CH_APOS) ? PH_APOS : PH_NONE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         col_mod_ff  <= '0;
         in_quote_ff <= 1'b0;
         tabs_ff     <= '0;
         spaces_ff   <= '0;
         phase_ff    <= PH_NONE;
      end else begin
         column_ff   <= column_in;
         col_mod_ff  <= col_mod_in;
         in_quote_ff <= in_quote_in;
         tabs_ff     <= tabs_in;
         spaces_ff   <= spaces_in;
         phase_ff    <= phase_in;
      end
   end

endmodule

FILE: rtl/stp_queue.sv
// Short operation queue between front and back ends.
// Depends on stp_pkg for the operation type and depth.
module stp_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  stp_pkg::op_type push_op,
   output logic            full,
   output logic            head_valid,
   output stp_pkg::op_type head_op,
   input  logic            pop
);

   stp_pkg::op_type              mem_ff [stp_pkg::QUEUE_DEPTH];
   logic [stp_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [stp_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [stp_pkg::QCNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == stp_pkg::QCNT_W'(stp_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_op    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == stp_pkg::QPTR_W'(stp_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + stp_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == stp_pkg::QPTR_W'(stp_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + stp_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + stp_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - stp_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/stp_back.sv
// Back end: expands each queued operation into tab, space and byte beats
// and holds them in the output register. Depends on stp_pkg.
module stp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  stp_pkg::op_type             q_op,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [stp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [stp_pkg::RPT_W-1:0]   rsp_repeat_res,
   output logic                        rsp_last
);

   stp_pkg::op_type            cur_ff, cur_in;
   logic                       cur_v_ff, cur_v_in;
   logic                       out_v_ff, out_v_in;
   logic [stp_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [stp_pkg::RPT_W-1:0]  out_rpt_ff, out_rpt_in;
   logic                       out_last_ff, out_last_in;

   logic advance;
   logic cur_done;

   assign advance  = cur_v_ff && (!out_v_ff || !rsp_stall);
   assign cur_done = advance && (cur_ff.tabs == '0) && (cur_ff.spaces == '0);
   assign q_pop    = q_valid && (!cur_v_ff || cur_done);

   // tab run first, then space run, then the byte itself
   always_comb begin
      if (cur_ff.tabs != '0) begin
         out_byte_in = stp_pkg::CH_TAB;
         out_rpt_in  = cur_ff.tabs;
         out_last_in = 1'b0;
      end else if (cur_ff.spaces != '0) begin
         out_byte_in = stp_pkg::CH_SPACE;
         out_rpt_in  = cur_ff.spaces;
         out_last_in = 1'b0;
      end else begin
         out_byte_in = cur_ff.ch;
         out_rpt_in  = stp_pkg::RPT_W'(1);
         out_last_in = cur_ff.last;
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (q_pop) begin
         cur_in = q_op;
      end else if (advance) begin
         if (cur_ff.tabs != '0) begin
            cur_in.tabs = '0;
         end else begin
            cur_in.spaces = '0;
         end
      end
      cur_v_in = q_pop ? 1'b1 : (cur_done ? 1'b0 : cur_v_ff);
      out_v_in = advance ? 1'b1 : (rsp_stall ? out_v_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         out_byte_ff <= out_byte_in;
         out_rpt_ff  <= out_rpt_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         cur_v_ff <= cur_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_repeat_res = out_rpt_ff;
   assign rsp_last       = out_last_ff;

endmodule

FILE: rtl/space_to_tab_packer.sv
// Space-to-tab packer top level. An accepted input beat reaches its first
// result beat via the queue, current-op and output registers. Throughput:
// one input beat per cycle while the queue is not full; the 2-entry queue
// absorbs an item whose tab, space and byte beats hold the output stage.
// Synchronous reset clears column, quote mode, pending runs and the queue.
module space_to_tab_packer #(
   parameter int unsigned LINE_LENGTH = stp_pkg::LINE_LENGTH_DEF,
   parameter int unsigned TAB_WIDTH   = stp_pkg::TAB_WIDTH_DEF,
   parameter int unsigned LAST_STOP   = stp_pkg::LAST_STOP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [stp_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_end_of_line,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [stp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [stp_pkg::RPT_W-1:0]   rsp_repeat_res,
   output logic                        rsp_last
);

   logic            q_push;
   stp_pkg::op_type q_push_op;
   logic            q_full;
   logic            q_head_valid;
   stp_pkg::op_type q_head_op;
   logic            q_pop;

   stp_front #(
      .LINE_LENGTH (LINE_LENGTH),
      .TAB_WIDTH   (TAB_WIDTH),
      .LAST_STOP   (LAST_STOP)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_line (req_end_of_line),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_op            (q_push_op)
   );

   stp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_push_op),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_op    (q_head_op),
      .pop        (q_pop)
   );

   stp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_head_valid),
      .q_op           (q_head_op),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_repeat_res (rsp_repeat_res),
      .rsp_last       (rsp_last)
   );

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("operation pushed into a full queue");

   a_last_is_cr : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_byte == stp_pkg::CH_CR)
      else $error("last set on a beat other than CR");

   a_repeat_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_res != '0)
      else $error("result beat with zero repeat count");

   a_pop_needs_data : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("pop from an empty queue");

endmodule
